@@ design/plist_pkg.sv @@
// Shared types, codes and sizes for the positional list engine.
package plist_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 7;
  localparam int CNT_W        = 7;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } plist_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;
  } plist_out_t;

endpackage

@@ design/positional_list_engine_top.sv @@
// Positional list engine: ring-store list with insert, delete and clear requests.
//
// Takes one request at a time and returns one result per request. A request
// runs through a small sequencer around one modular ring-index adder and a
// single-write, single-read store of CAPACITY words. An insert or delete in
// the middle moves every entry behind the position by one slot, one entry per
// cycle through the store. Each request is checked first; an accepted middle
// insert or delete then sets up and runs that move, an accepted insert writes
// its value, and the head and tail entries are read back before the result is
// offered, except when the list is left empty, which reports zero for both.
// The next request is taken once the result has left without a stall.
// Stored words are undefined after reset; only written entries are ever reported.
module positional_list_engine_top #(
  parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  plist_pkg::plist_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output plist_pkg::plist_out_t out_data
);

  localparam int DW = plist_pkg::DATA_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = ((CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W) + 1;

  localparam logic [AW-1:0] SLOT_LAST = AW'(CAPACITY - 1);
  localparam logic [CW:0]   CAP_SUM   = (CW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_SETUP    = 4'd2;
  localparam logic [3:0] S_SHIFT    = 4'd3;
  localparam logic [3:0] S_WRITE    = 4'd4;
  localparam logic [3:0] S_RD_HEAD  = 4'd5;
  localparam logic [3:0] S_RD_TAIL  = 4'd6;
  localparam logic [3:0] S_CAP_TAIL = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    slot_dec = (s == '0) ? SLOT_LAST : s - 1'b1;
  endfunction

  logic [DW-1:0] mem [CAPACITY];

  logic [3:0]                     state_r, state_nxt;
  logic [AW-1:0]                  start_r, start_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [CW-1:0]                  rem_r, rem_nxt;
  logic                           pend_r, pend_nxt;
  logic                           ins_r, ins_nxt;
  logic [AW-1:0]                  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]                  rd_ptr_r, rd_ptr_nxt;
  logic [plist_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic [plist_pkg::MODE_W-1:0]   mode_r;
  logic [plist_pkg::POS_W-1:0]    pos_r;
  logic [DW-1:0]                  value_r;
  logic [DW-1:0]                  head_r;
  logic [DW-1:0]                  tail_r;
  logic [DW-1:0]                  rd_data_r;

  logic [CW-1:0] add_k;
  logic [CW:0]   add_sum;
  logic [AW-1:0] add_slot;
  logic [LW-1:0] pos_x;
  logic [LW-1:0] cnt_x;
  logic [CW-1:0] pos_c;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  assign pos_x = LW'(pos_r);
  assign cnt_x = LW'(count_r);
  assign pos_c = CW'(pos_r);

  // ring index adder: slot of logical position add_k
  always_comb begin
    add_k = count_r;
    case (state_r)
      S_CHECK: begin
        add_k = (mode_r == plist_pkg::MODE_INSERT) ? count_r : pos_c - 1'b1;
      end
      S_RD_TAIL: begin
        add_k = count_r - 1'b1;
      end
      default: begin
        add_k = count_r;
      end
    endcase
    add_sum  = (CW+1)'(start_r) + (CW+1)'(add_k);
    add_slot = (add_sum >= CAP_SUM) ? AW'(add_sum - CAP_SUM) : AW'(add_sum);
  end

  always_comb begin
    state_nxt  = state_r;
    start_nxt  = start_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    ins_nxt    = ins_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = wr_ptr_r;
    mem_wdata  = rd_data_r;
    mem_re     = 1'b0;
    mem_raddr  = rd_ptr_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = plist_pkg::ST_OK;
        state_nxt  = S_RD_HEAD;
        case (mode_r)
          plist_pkg::MODE_INSERT: begin
            ins_nxt = 1'b1;
            if (pos_r == '0 || pos_x > cnt_x + 1'b1) begin
              status_nxt = plist_pkg::ST_RANGE;
            end else if (count_r == CAP_CNT) begin
              status_nxt = plist_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + 1'b1;
              if (pos_r == plist_pkg::POS_W'(1)) begin
                start_nxt  = slot_dec(start_r);
                wr_ptr_nxt = slot_dec(start_r);
                state_nxt  = S_WRITE;
              end else begin
                wr_ptr_nxt = add_slot;
                rem_nxt    = count_r - pos_c + 1'b1;
                state_nxt  = S_SETUP;
              end
            end
          end
          plist_pkg::MODE_DELETE: begin
            ins_nxt = 1'b0;
            if (count_r == '0) begin
              status_nxt = plist_pkg::ST_EMPTY;
            end else if (pos_r == '0 || pos_x > cnt_x) begin
              status_nxt = plist_pkg::ST_RANGE;
            end else begin
              count_nxt = count_r - 1'b1;
              if (pos_r == plist_pkg::POS_W'(1)) begin
                start_nxt = slot_inc(start_r);
              end else begin
                wr_ptr_nxt = add_slot;
                rem_nxt    = count_r - pos_c;
                state_nxt  = S_SETUP;
              end
            end
          end
          plist_pkg::MODE_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            status_nxt = plist_pkg::ST_OK;
          end
        endcase
      end
      S_SETUP: begin
        rd_ptr_nxt = ins_r ? slot_dec(wr_ptr_r) : slot_inc(wr_ptr_r);
        pend_nxt   = 1'b0;
        state_nxt  = S_SHIFT;
      end
      S_SHIFT: begin
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_waddr  = wr_ptr_r;
          mem_wdata  = rd_data_r;
          wr_ptr_nxt = ins_r ? slot_dec(wr_ptr_r) : slot_inc(wr_ptr_r);
        end
        if (rem_r != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r;
          rd_ptr_nxt = ins_r ? slot_dec(rd_ptr_r) : slot_inc(rd_ptr_r);
          rem_nxt    = rem_r - 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ins_r ? S_WRITE : S_RD_HEAD;
        end
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr_r;
        mem_wdata = value_r;
        state_nxt = S_RD_HEAD;
      end
      S_RD_HEAD: begin
        if (count_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = start_r;
          state_nxt = S_RD_TAIL;
        end
      end
      S_RD_TAIL: begin
        mem_re    = 1'b1;
        mem_raddr = add_slot;
        state_nxt = S_CAP_TAIL;
      end
      S_CAP_TAIL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      start_r  <= '0;
      count_r  <= '0;
      rem_r    <= '0;
      pend_r   <= 1'b0;
      ins_r    <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      status_r <= plist_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      rem_r    <= rem_nxt;
      pend_r   <= pend_nxt;
      ins_r    <= ins_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      status_r <= status_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      mode_r  <= in_data.mode;
      pos_r   <= in_data.position;
      value_r <= in_data.value;
    end
    if (state_r == S_RD_HEAD && count_r == '0) begin
      head_r <= '0;
      tail_r <= '0;
    end
    if (state_r == S_RD_TAIL) begin
      head_r <= rd_data_r;
    end
    if (state_r == S_CAP_TAIL) begin
      tail_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_data.status     = status_r;
  assign out_data.count      = plist_pkg::CNT_W'(count_r);
  assign out_data.head_value = head_r;
  assign out_data.tail_value = tail_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("list count above capacity");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while a result is pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && count_r == '0) |-> (head_r == '0 && tail_r == '0))
    else $error("empty list reports nonzero head or tail");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r == plist_pkg::ST_FULL) |-> (count_r == CAP_CNT))
    else $error("full status with list not full");

  a_shift_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && rem_r == '0) |=> !pend_r)
    else $error("store move left pending after shift");

endmodule
